// ===== hw/rtl/radix_trie_id_map_top_macros.svh =====
// assertion macros shared by the radix trie id map rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef RADIX_TRIE_ID_MAP_TOP_MACROS_SVH
`define RADIX_TRIE_ID_MAP_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RTIM_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("rtim assertion failed");
`define RTIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("rtim assertion failed");
`else
`define RTIM_ASSERT(lbl, clk, rst_n, cond)
`define RTIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/rtim_pkg.sv =====
// shared constants, codes, types and helpers of the radix trie id map
// no dependencies
package rtim_pkg;
	localparam int LEVELS         = 4;
	localparam int LVL_W          = 2;
	localparam int MAX_LEVEL_BITS = 8;
	localparam int BITS_W         = 4;
	localparam int NODE_BLOCKS    = 1024;
	localparam int LEAF_CAP       = 65536;
	localparam int ID_BITS        = 32;
	localparam int TOT_W          = $clog2(LEVELS * MAX_LEVEL_BITS + 1);
	localparam int CFG_AW         = 3;
	localparam int CFG_DW         = 4;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [2:0] ST_FOUND    = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_ABSENT   = 3'd2;
	localparam logic [2:0] ST_REMOVED  = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic [CFG_AW-1:0] CFG_LEVELS = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_BITS0  = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_BITS1  = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_BITS2  = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_BITS3  = 3'd4;

	typedef struct packed {
		logic [LVL_W-1:0]                 last_lvl;
		logic [LEVELS-1:0][BITS_W-1:0]    bits;
	} geom_t;

	typedef logic [LEVELS-1:0][MAX_LEVEL_BITS-1:0] fields_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] dense_index;
		logic [18:0] table_slots;
	} rsp_t;

	// low ones mask of a level field, bits in 1..MAX_LEVEL_BITS
	function automatic logic [MAX_LEVEL_BITS-1:0] level_mask(input logic [BITS_W-1:0] bits);
		logic [MAX_LEVEL_BITS-1:0] ones;
		ones = '1;
		return ones >> (BITS_W'(MAX_LEVEL_BITS) - bits);
	endfunction
endpackage

// ===== hw/rtl/rtim_req_if.sv =====
// request channel of the radix trie id map
// depends on rtim_pkg
interface rtim_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  action;
	logic [rtim_pkg::ID_BITS-1:0] vertex_id;
	modport source (output valid, action, vertex_id, input ready);
	modport sink (input valid, action, vertex_id, output ready);
endinterface

// ===== hw/rtl/rtim_rsp_if.sv =====
// result channel of the radix trie id map
// no dependencies
interface rtim_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] dense_index;
	logic [18:0] table_slots;
	modport source (output valid, status, dense_index, table_slots, input ready);
	modport sink (input valid, status, dense_index, table_slots, output ready);
endinterface

// ===== hw/rtl/rtim_cfg_if.sv =====
// configuration write channel of the radix trie id map
// depends on rtim_pkg
interface rtim_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [rtim_pkg::CFG_AW-1:0] addr;
	logic [rtim_pkg::CFG_DW-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/radix_trie_id_map_top.sv =====
// lookup/remove: a table read and evaluate per level, then leaf mark read, result, hand-off
// insert of a new path: each new block is allocated and its slots cleared by a sweep, in place
// of its level read; a new leaf under an existing path adds a new-leaf step
// throughput: one request at a time; the next is taken once the result reaches the output register
// reset and each config write to a listed register empty the map by sweeping the root slots,
// during which no request is taken; the removed-mark ram is never cleared
// top level: config registers, geometry split, sequencer and result register
// depends on rtim_pkg, rtim_*_if, rtim_split, rtim_ctrl
module radix_trie_id_map_top #(
	parameter int NODE_BLOCKS = rtim_pkg::NODE_BLOCKS,
	parameter int LEAF_CAP    = rtim_pkg::LEAF_CAP
) (
	input logic        clk,
	input logic        arst_n,
	rtim_req_if.sink   req,
	rtim_rsp_if.source rsp,
	rtim_cfg_if.sink   cfg
);
	// configuration registers, raw values, clamped in the split stage
	logic [2:0]                                        levels_q;
	logic [rtim_pkg::LEVELS-1:0][rtim_pkg::BITS_W-1:0] bits_q;
	logic                                              cfg_wr;

	rtim_pkg::geom_t   geom;
	rtim_pkg::fields_t fields;
	logic              idle;
	logic              out_free;
	logic              rsp_load;
	rtim_pkg::rsp_t    rsp_next;

	// result register
	logic              rsp_valid_q;
	rtim_pkg::rsp_t    rsp_q;

	// config writes are always taken; any listed register empties the map
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && (cfg.addr <= rtim_pkg::CFG_BITS3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= 3'd3;
			bits_q   <= {rtim_pkg::LEVELS{4'd8}};
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				rtim_pkg::CFG_LEVELS: levels_q  <= cfg.data[2:0];
				rtim_pkg::CFG_BITS0:  bits_q[0] <= cfg.data;
				rtim_pkg::CFG_BITS1:  bits_q[1] <= cfg.data;
				rtim_pkg::CFG_BITS2:  bits_q[2] <= cfg.data;
				rtim_pkg::CFG_BITS3:  bits_q[3] <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// per-level fields of the incoming id, latched by the sequencer on accept
	rtim_split u_split (
		.levels_in_use(levels_q),
		.level_bits(bits_q),
		.vertex_id(req.vertex_id),
		.geom(geom),
		.fields(fields)
	);

	// request accepted only while the sequencer sits idle
	assign req.ready = idle;

	rtim_ctrl #(.NODE_BLOCKS(NODE_BLOCKS), .LEAF_CAP(LEAF_CAP)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_wr),
		.geom(geom),
		.fields(fields),
		.start(req.valid && idle),
		.action(req.action),
		.idle(idle),
		.out_free(out_free),
		.rsp_load(rsp_load),
		.rsp(rsp_next)
	);

	// output register frees the sequencer as soon as the result is parked
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.dense_index = rsp_q.dense_index;
	assign rsp.table_slots = rsp_q.table_slots;
endmodule

// ===== hw/rtl/rtim_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module rtim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/rtim_split.sv =====
// clamps the level geometry and cuts an identifier into per-level fields
// depends on rtim_pkg
module rtim_split (
	input  logic [2:0]                                        levels_in_use,
	input  logic [rtim_pkg::LEVELS-1:0][rtim_pkg::BITS_W-1:0] level_bits,
	input  logic [rtim_pkg::ID_BITS-1:0]                      vertex_id,
	output rtim_pkg::geom_t                                   geom,
	output rtim_pkg::fields_t                                 fields
);
	always_comb begin
		logic [2:0]                  lv;
		logic [rtim_pkg::BITS_W-1:0] b;
		logic [rtim_pkg::TOT_W-1:0]  total;
		logic [rtim_pkg::TOT_W-1:0]  used;
		logic [rtim_pkg::TOT_W-1:0]  sh;
		lv = levels_in_use;
		if (lv == 3'd0) begin
			lv = 3'd1;
		end
		if (lv > 3'(rtim_pkg::LEVELS)) begin
			lv = 3'(rtim_pkg::LEVELS);
		end
		geom.last_lvl = rtim_pkg::LVL_W'(lv - 3'd1);
		for (int i = 0; i < rtim_pkg::LEVELS; i++) begin
			b = level_bits[i];
			if (b == '0) begin
				b = rtim_pkg::BITS_W'(1);
			end
			if (b > rtim_pkg::BITS_W'(rtim_pkg::MAX_LEVEL_BITS)) begin
				b = rtim_pkg::BITS_W'(rtim_pkg::MAX_LEVEL_BITS);
			end
			geom.bits[i] = b;
		end
		total = '0;
		for (int i = 0; i < rtim_pkg::LEVELS; i++) begin
			if (rtim_pkg::LVL_W'(i) <= geom.last_lvl) begin
				total = total + rtim_pkg::TOT_W'(geom.bits[i]);
			end
		end
		// top level takes the most significant used bits
		used = '0;
		for (int i = 0; i < rtim_pkg::LEVELS; i++) begin
			used = used + rtim_pkg::TOT_W'(geom.bits[i]);
			sh = total - used;
			fields[i] = rtim_pkg::MAX_LEVEL_BITS'(vertex_id >> sh)
				& rtim_pkg::level_mask(geom.bits[i]);
		end
	end
endmodule

// ===== hw/rtl/rtim_ctrl.sv =====
// walk / allocate / clear sequencer around the child table and removed-mark rams
// depends on rtim_pkg, rtim_ram and the assertion macro header
`include "radix_trie_id_map_top_macros.svh"
module rtim_ctrl #(
	parameter int NODE_BLOCKS = rtim_pkg::NODE_BLOCKS,
	parameter int LEAF_CAP    = rtim_pkg::LEAF_CAP
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr,
	input  rtim_pkg::geom_t   geom,
	input  rtim_pkg::fields_t fields,
	input  logic              start,
	input  logic [1:0]        action,
	output logic              idle,
	input  logic              out_free,
	output logic              rsp_load,
	output rtim_pkg::rsp_t    rsp
);
	localparam int MLB    = rtim_pkg::MAX_LEVEL_BITS;
	localparam int LVL_W  = rtim_pkg::LVL_W;
	localparam int BLK_W  = $clog2(NODE_BLOCKS);
	localparam int BLKC_W = $clog2(NODE_BLOCKS + 1);
	localparam int LIX_W  = $clog2(LEAF_CAP);
	localparam int LCNT_W = $clog2(LEAF_CAP + 1);
	localparam int ENT_W  = (LCNT_W > BLKC_W) ? LCNT_W : BLKC_W;
	localparam int CMP_W  = ENT_W + 1;
	localparam int SLOT_W = BLK_W + MLB + 1;
	localparam int AW     = BLK_W + MLB;

	localparam logic [3:0] S_INIT    = 4'd0;
	localparam logic [3:0] S_CLR     = 4'd1;
	localparam logic [3:0] S_IDLE    = 4'd2;
	localparam logic [3:0] S_RD      = 4'd3;
	localparam logic [3:0] S_EV      = 4'd4;
	localparam logic [3:0] S_LEAF    = 4'd5;
	localparam logic [3:0] S_ALLOC   = 4'd6;
	localparam logic [3:0] S_NEWLEAF = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0]        state_q;
	logic [1:0]        act_q;
	rtim_pkg::fields_t fld_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [BLK_W-1:0]  blk_q;
	logic [ENT_W-1:0]  e_q;
	logic [MLB-1:0]    clr_cnt_q;
	logic [MLB-1:0]    clr_lim_q;
	logic [BLK_W-1:0]  clr_blk_q;
	logic              clr_root_q;
	logic [BLKC_W-1:0] block_count_q;
	logic [LCNT_W-1:0] leaf_count_q;
	logic [SLOT_W-1:0] slot_q;
	logic [2:0]        st_q;
	logic [LIX_W-1:0]  idx_q;

	logic              c_we;
	logic [AW-1:0]     c_waddr;
	logic [ENT_W-1:0]  c_wdata;
	logic [AW-1:0]     c_raddr;
	logic [ENT_W-1:0]  c_rdata;
	logic              r_we;
	logic [LIX_W-1:0]  r_waddr;
	logic              r_wdata;
	logic [LIX_W-1:0]  r_raddr;
	logic              r_rdata;

	logic              int_hit;
	logic              blk_full;
	logic              leaf_full;
	logic              exists;
	logic              live;
	logic [LVL_W-1:0]  nl;

	rtim_ram #(.WIDTH(ENT_W), .DEPTH(NODE_BLOCKS * (2 ** MLB))) u_child (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);

	rtim_ram #(.WIDTH(1), .DEPTH(LEAF_CAP)) u_removed (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	assign nl       = lvl_q + 1'b1;
	assign c_raddr  = {blk_q, fld_q[lvl_q]};
	assign r_raddr  = LIX_W'(c_rdata - 1'b1);
	assign int_hit  = (c_rdata != '0) && (CMP_W'(c_rdata) < CMP_W'(block_count_q));
	assign blk_full = (CMP_W'(block_count_q) + CMP_W'(geom.last_lvl - lvl_q))
		> CMP_W'(NODE_BLOCKS);
	assign leaf_full = leaf_count_q >= LCNT_W'(LEAF_CAP);
	assign exists   = (e_q != '0) && (CMP_W'(e_q - 1'b1) < CMP_W'(leaf_count_q));
	assign live     = exists && !r_rdata;
	assign idle     = (state_q == S_IDLE);
	assign rsp_load = (state_q == S_DONE) && out_free;

	always_comb begin
		rsp.status      = st_q;
		rsp.dense_index = (st_q == rtim_pkg::ST_FOUND || st_q == rtim_pkg::ST_INSERTED)
			? 16'(idx_q) : 16'd0;
		rsp.table_slots = 19'(slot_q);
	end

	always_comb begin
		c_we    = 1'b0;
		c_waddr = {blk_q, fld_q[lvl_q]};
		c_wdata = '0;
		r_we    = 1'b0;
		r_waddr = LIX_W'(e_q - 1'b1);
		r_wdata = 1'b0;
		case (state_q)
			S_CLR: begin
				c_we    = 1'b1;
				c_waddr = {clr_blk_q, clr_cnt_q};
			end
			S_ALLOC: begin
				c_we    = 1'b1;
				c_wdata = ENT_W'(block_count_q);
			end
			S_NEWLEAF: begin
				c_we    = 1'b1;
				c_wdata = ENT_W'(leaf_count_q) + 1'b1;
				r_we    = 1'b1;
				r_waddr = LIX_W'(leaf_count_q);
			end
			S_LEAF: begin
				if (act_q == rtim_pkg::ACT_REMOVE) begin
					r_we    = live;
					r_wdata = 1'b1;
				end else if (act_q == rtim_pkg::ACT_INSERT) begin
					r_we = exists && !live;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			block_count_q <= BLKC_W'(1);
			leaf_count_q  <= '0;
			slot_q        <= '0;
			clr_root_q    <= 1'b1;
		end else if (cfg_wr) begin
			state_q <= S_INIT;
		end else begin
			case (state_q)
				S_INIT: begin
					leaf_count_q  <= '0;
					block_count_q <= BLKC_W'(1);
					slot_q        <= SLOT_W'(1) << geom.bits[0];
					clr_blk_q     <= '0;
					clr_cnt_q     <= '0;
					clr_lim_q     <= rtim_pkg::level_mask(geom.bits[0]);
					clr_root_q    <= 1'b1;
					state_q       <= S_CLR;
				end
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == clr_lim_q) begin
						if (clr_root_q) begin
							state_q <= S_IDLE;
						end else if (lvl_q == geom.last_lvl) begin
							state_q <= S_NEWLEAF;
						end else begin
							state_q <= S_ALLOC;
						end
					end
				end
				S_IDLE: begin
					if (start) begin
						act_q   <= action;
						fld_q   <= fields;
						lvl_q   <= '0;
						blk_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					e_q <= c_rdata;
					if (lvl_q == geom.last_lvl) begin
						state_q <= S_LEAF;
					end else if (int_hit) begin
						blk_q   <= BLK_W'(c_rdata);
						lvl_q   <= nl;
						state_q <= S_RD;
					end else if (act_q == rtim_pkg::ACT_INSERT) begin
						if (blk_full || leaf_full) begin
							st_q <= rtim_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							state_q <= S_ALLOC;
						end
					end else begin
						st_q    <= rtim_pkg::ST_ABSENT;
						state_q <= S_DONE;
					end
				end
				S_ALLOC: begin
					blk_q         <= BLK_W'(block_count_q);
					clr_blk_q     <= BLK_W'(block_count_q);
					block_count_q <= block_count_q + 1'b1;
					slot_q        <= slot_q + (SLOT_W'(1) << geom.bits[nl]);
					clr_lim_q     <= rtim_pkg::level_mask(geom.bits[nl]);
					clr_cnt_q     <= '0;
					clr_root_q    <= 1'b0;
					lvl_q         <= nl;
					state_q       <= S_CLR;
				end
				S_NEWLEAF: begin
					idx_q        <= LIX_W'(leaf_count_q);
					leaf_count_q <= leaf_count_q + 1'b1;
					st_q         <= rtim_pkg::ST_INSERTED;
					state_q      <= S_DONE;
				end
				S_LEAF: begin
					idx_q   <= LIX_W'(e_q - 1'b1);
					state_q <= S_DONE;
					if (act_q == rtim_pkg::ACT_REMOVE) begin
						st_q <= live ? rtim_pkg::ST_REMOVED : rtim_pkg::ST_ABSENT;
					end else if (live) begin
						st_q <= rtim_pkg::ST_FOUND;
					end else if (act_q == rtim_pkg::ACT_INSERT) begin
						if (exists) begin
							st_q <= rtim_pkg::ST_INSERTED;
						end else if (leaf_full) begin
							st_q <= rtim_pkg::ST_FULL;
						end else begin
							state_q <= S_NEWLEAF;
						end
					end else begin
						st_q <= rtim_pkg::ST_ABSENT;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	`RTIM_ASSERT(a_blk_bound, clk, arst_n, block_count_q != '0 && CMP_W'(block_count_q) <= CMP_W'(NODE_BLOCKS))
	`RTIM_ASSERT(a_leaf_bound, clk, arst_n, CMP_W'(leaf_count_q) <= CMP_W'(LEAF_CAP))
	`RTIM_ASSERT_NEXT(a_leaf_grow, clk, arst_n, state_q == S_NEWLEAF && !cfg_wr, leaf_count_q == LCNT_W'($past(leaf_count_q) + 1'b1))
endmodule

// ===== bench/id_map_checker.sv =====
// checker of the radix trie id map: watches the request, result and config channels,
// keeps its own copy of the tree and compares each result in order
// depends on rtim_pkg and the rtim_*_if interfaces
module id_map_checker (
	input  logic clk,
	input  logic arst_n,
	rtim_req_if  req,
	rtim_rsp_if  rsp,
	rtim_cfg_if  cfg,
	output int   fails,
	output int   pending
);
	localparam int unsigned BLOCK_SLOTS = 1 << rtim_pkg::MAX_LEVEL_BITS;

	logic [2:0] lvl_reg;
	logic [3:0] bits_reg [rtim_pkg::LEVELS];
	int unsigned child_ram [int unsigned];
	bit leaf_gone [int unsigned];
	int unsigned leaf_cnt, blk_cnt, slot_cnt;
	rtim_pkg::rsp_t want_rsp [$];

	initial fails = 0;

	function automatic int unsigned eff_levels();
		int unsigned n;
		n = lvl_reg;
		if (n < 1) n = 1;
		if (n > rtim_pkg::LEVELS) n = rtim_pkg::LEVELS;
		return n;
	endfunction

	function automatic int unsigned eff_bits(int unsigned lvl);
		int unsigned b;
		b = bits_reg[lvl];
		if (b < 1) b = 1;
		if (b > rtim_pkg::MAX_LEVEL_BITS) b = rtim_pkg::MAX_LEVEL_BITS;
		return b;
	endfunction

	function automatic int unsigned rd_slot(int unsigned a);
		return child_ram.exists(a) ? child_ram[a] : 0;
	endfunction

	function automatic void empty_map();
		child_ram.delete();
		leaf_cnt = 0;
		blk_cnt = 1;
		slot_cnt = 1 << eff_bits(0);
	endfunction

	// one request against the tree copy, returns the result it must produce
	function automatic rtim_pkg::rsp_t map_step(logic [1:0] act, logic [31:0] id);
		int unsigned nlev, total, used, blk, miss, e, at, need, nb, idx;
		int unsigned fld [rtim_pkg::LEVELS];
		logic [2:0] status;
		bit exists, live;
		rtim_pkg::rsp_t r;
		nlev = eff_levels();
		total = 0;
		used = 0;
		for (int i = 0; i < nlev; i++) total += eff_bits(i);
		for (int i = 0; i < nlev; i++) begin
			used += eff_bits(i);
			fld[i] = (id >> (total - used)) & ((1 << eff_bits(i)) - 1);
		end
		status = rtim_pkg::ST_ABSENT;
		idx = 0;
		blk = 0;
		miss = nlev;
		for (int i = 0; i + 1 < nlev; i++) begin
			e = rd_slot(blk * BLOCK_SLOTS + fld[i]);
			// stale block numbers count as empty
			if (e == 0 || e >= blk_cnt) begin
				miss = i;
				break;
			end
			blk = e;
		end
		if (miss < nlev) begin
			if (act == rtim_pkg::ACT_INSERT) begin
				need = nlev - 1 - miss;
				if (blk_cnt + need > rtim_pkg::NODE_BLOCKS || leaf_cnt >= rtim_pkg::LEAF_CAP) begin
					status = rtim_pkg::ST_FULL;
				end else begin
					for (int i = miss; i + 1 < nlev; i++) begin
						nb = blk_cnt;
						blk_cnt++;
						for (int k = 0; k < BLOCK_SLOTS; k++) child_ram.delete(nb * BLOCK_SLOTS + k);
						slot_cnt += 1 << eff_bits(i + 1);
						child_ram[blk * BLOCK_SLOTS + fld[i]] = nb;
						blk = nb;
					end
					idx = leaf_cnt;
					leaf_cnt++;
					leaf_gone[idx] = 1'b0;
					child_ram[blk * BLOCK_SLOTS + fld[nlev - 1]] = idx + 1;
					status = rtim_pkg::ST_INSERTED;
				end
			end
		end else begin
			at = blk * BLOCK_SLOTS + fld[nlev - 1];
			e = rd_slot(at);
			exists = e != 0 && e - 1 < leaf_cnt;
			live = exists && !leaf_gone[e - 1];
			if (act == rtim_pkg::ACT_REMOVE) begin
				if (live) begin
					leaf_gone[e - 1] = 1'b1;
					status = rtim_pkg::ST_REMOVED;
				end
			end else if (live) begin
				status = rtim_pkg::ST_FOUND;
				idx = e - 1;
			end else if (act == rtim_pkg::ACT_INSERT) begin
				if (exists) begin
					leaf_gone[e - 1] = 1'b0;
					idx = e - 1;
					status = rtim_pkg::ST_INSERTED;
				end else if (leaf_cnt >= rtim_pkg::LEAF_CAP) begin
					status = rtim_pkg::ST_FULL;
				end else begin
					idx = leaf_cnt;
					leaf_cnt++;
					leaf_gone[idx] = 1'b0;
					child_ram[at] = idx + 1;
					status = rtim_pkg::ST_INSERTED;
				end
			end
		end
		r.status = status;
		r.dense_index = (status <= rtim_pkg::ST_INSERTED) ? idx[15:0] : 16'd0;
		r.table_slots = slot_cnt[18:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rtim_pkg::rsp_t w;
		if (!arst_n) begin
			lvl_reg = 3'd3;
			for (int i = 0; i < rtim_pkg::LEVELS; i++) bits_reg[i] = 4'd8;
			leaf_gone.delete();
			empty_map();
			want_rsp.delete();
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					rtim_pkg::CFG_LEVELS: lvl_reg = cfg.data[2:0];
					rtim_pkg::CFG_BITS0: bits_reg[0] = cfg.data;
					rtim_pkg::CFG_BITS1: bits_reg[1] = cfg.data;
					rtim_pkg::CFG_BITS2: bits_reg[2] = cfg.data;
					rtim_pkg::CFG_BITS3: bits_reg[3] = cfg.data;
					default: ;
				endcase
				if (cfg.addr <= rtim_pkg::CFG_BITS3) empty_map();
			end
			if (rsp.valid && rsp.ready) begin
				if (want_rsp.size() == 0) begin
					$error("result with no request outstanding");
					fails++;
				end else begin
					w = want_rsp.pop_front();
					if (rsp.status !== w.status) begin
						$error("status expected %0d got %0d", w.status, rsp.status);
						fails++;
					end
					if (rsp.dense_index !== w.dense_index) begin
						$error("dense_index expected %0d got %0d", w.dense_index, rsp.dense_index);
						fails++;
					end
					if (rsp.table_slots !== w.table_slots) begin
						$error("table_slots expected %0d got %0d", w.table_slots, rsp.table_slots);
						fails++;
					end
				end
			end
			if (req.valid && req.ready) want_rsp.push_back(map_step(req.action, req.vertex_id));
			pending <= want_rsp.size();
		end
	end
endmodule

// ===== bench/tb_radix_trie_id_map_top.sv =====
// top of the radix trie id map bench: clock, reset, stimulus and verdict
// depends on rtim_pkg, the rtim_*_if interfaces, radix_trie_id_map_top and id_map_checker
module tb_radix_trie_id_map_top;
	logic clk;
	logic arst_n;
	int fails;
	int pending;
	bit quiet;       // phase with no idling on either side
	bit long_hold;   // asks the result side for one long stall
	logic [31:0] id_pool [$];

	rtim_req_if req_ch ();
	rtim_rsp_if rsp_ch ();
	rtim_cfg_if cfg_ch ();

	radix_trie_id_map_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	id_map_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.cfg     (cfg_ch),
		.fails   (fails),
		.pending (pending)
	);

	// 10 unit clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#60000000;
		$display("radix_trie_id_map_top regression: fail");
		$finish;
	end

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 6);
	endfunction

	// result side: random stall per result, one long stall on request
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (long_hold) begin
				// hold off long enough for the request side to back up
				rsp_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end
			stall = draw_gap();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
		end
	end

	// one request; valid stays high when the next one follows with no gap
	task automatic send(logic [1:0] act, logic [31:0] id);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.vertex_id <= id;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// stop offering requests and wait for every result
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic cfg_write(logic [rtim_pkg::CFG_AW-1:0] a, logic [rtim_pkg::CFG_DW-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= a;
		cfg_ch.data <= d;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	// full geometry load; the map is emptied by each write
	task automatic set_geometry(logic [3:0] lv, logic [3:0] b0, logic [3:0] b1,
			logic [3:0] b2, logic [3:0] b3);
		cfg_write(rtim_pkg::CFG_LEVELS, lv);
		cfg_write(rtim_pkg::CFG_BITS0, b0);
		cfg_write(rtim_pkg::CFG_BITS1, b1);
		cfg_write(rtim_pkg::CFG_BITS2, b2);
		cfg_write(rtim_pkg::CFG_BITS3, b3);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		id_pool.delete();
	endtask

	// mostly reuse recent ids so inserts, lookups and removes meet each other
	function automatic logic [31:0] next_id(int reuse_pct);
		logic [31:0] v;
		if (id_pool.size() > 0 && $urandom_range(0, 99) < reuse_pct) begin
			v = id_pool[$urandom_range(0, id_pool.size() - 1)];
		end else begin
			v = $urandom;
			id_pool.push_back(v);
			if (id_pool.size() > 24) void'(id_pool.pop_front());
		end
		return v;
	endfunction

	function automatic logic [1:0] next_action(bit fill);
		int r;
		r = $urandom_range(0, 19);
		if (fill) return (r < 16) ? rtim_pkg::ACT_INSERT : rtim_pkg::ACT_LOOKUP;
		if (r < 8) return rtim_pkg::ACT_INSERT;
		if (r < 13) return rtim_pkg::ACT_LOOKUP;
		if (r < 18) return rtim_pkg::ACT_REMOVE;
		return 2'd3;   // unlisted action, behaves as a lookup
	endfunction

	initial begin
		logic [3:0] geo [6][5];
		int count [6];
		int reuse [6];
		arst_n = 1'b0;
		quiet = 1'b0;
		long_hold = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= rtim_pkg::ACT_LOOKUP;
		req_ch.vertex_id <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.addr <= rtim_pkg::CFG_LEVELS;
		cfg_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: two levels of two bits, one leaf walked through its life
		set_geometry(4'd2, 4'd2, 4'd2, 4'd8, 4'd8);
		send(rtim_pkg::ACT_LOOKUP, 32'd5);
		send(rtim_pkg::ACT_INSERT, 32'd5);
		send(rtim_pkg::ACT_INSERT, 32'd5);
		send(rtim_pkg::ACT_LOOKUP, 32'd5);
		send(rtim_pkg::ACT_REMOVE, 32'd5);
		send(rtim_pkg::ACT_REMOVE, 32'd5);
		send(rtim_pkg::ACT_LOOKUP, 32'd5);
		send(rtim_pkg::ACT_INSERT, 32'd5);          // revive keeps the old index
		send(rtim_pkg::ACT_INSERT, 32'd0);
		send(rtim_pkg::ACT_INSERT, 32'hffff_ffff);
		send(rtim_pkg::ACT_LOOKUP, 32'hffff_fff5);  // high bits ignored
		send(2'd3, 32'd5);
		send(2'd3, 32'h1234_5670);
		send(rtim_pkg::ACT_REMOVE, 32'd9);          // missing interior path
		send(rtim_pkg::ACT_INSERT, 32'd10);
		send(rtim_pkg::ACT_LOOKUP, 32'd10);
		drain();
		// index outside the register list changes nothing
		cfg_write(3'd5, 4'd3);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		send(rtim_pkg::ACT_LOOKUP, 32'd10);
		drain();

		// random phases: geometry, item count, id reuse percent
		geo[0] = '{4'd3, 4'd4, 4'd3, 4'd2, 4'd8};  count[0] = 300; reuse[0] = 60;
		geo[1] = '{4'd0, 4'd15, 4'd1, 4'd1, 4'd1}; count[1] = 150; reuse[1] = 60;
		geo[2] = '{4'd7, 4'd8, 4'd8, 4'd8, 4'd1};  count[2] = 450; reuse[2] = 15;
		geo[3] = '{4'd4, 4'd0, 4'd1, 4'd0, 4'd1};  count[3] = 200; reuse[3] = 60;
		geo[4] = '{4'd2, 4'd8, 4'd8, 4'd15, 4'd0}; count[4] = 300; reuse[4] = 60;
		geo[5] = '{4'd3, 4'd5, 4'd5, 4'd6, 4'd3};  count[5] = 300; reuse[5] = 60;
		for (int p = 0; p < 6; p++) begin
			set_geometry(geo[p][0], geo[p][1], geo[p][2], geo[p][3], geo[p][4]);
			quiet = (p == 4);
			for (int n = 0; n < count[p]; n++) begin
				if (p == 0 && n == 100) long_hold = 1'b1;
				// pause the request side until the block is empty
				if (p == 0 && n == 200) drain();
				// phase two sends mostly inserts to load up the node storage
				send(next_action(p == 2), next_id(reuse[p]));
			end
			drain();
		end
		quiet = 1'b0;

		repeat (50) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("radix_trie_id_map_top regression: pass");
		end else begin
			$display("radix_trie_id_map_top regression: fail");
		end
		$finish;
	end
endmodule
